FILE: rtl/ccr_pkg.sv
// Shared types, codes and pipeline depths of the circle collision response block.
package ccr_pkg;

	// Coordinate lane width: lanes are read from and saturated to this many bits.
	localparam int COORD_WIDTH = 32;

	// Depth of the square root and of the divider pipelines.
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = 31;

	// Restitution after reset: 0.8 in unsigned Q1.15.
	localparam logic [15:0] REST_RESET = 16'd26214;
	localparam logic [16:0] Q15_ONE    = 17'd32768;

	// Kinds of the other body.
	localparam logic [1:0] OP_CIRCLE = 2'd0;
	localparam logic [1:0] OP_BOX    = 2'd1;
	localparam logic [1:0] OP_UNSUP  = 2'd2;

	// Context of one request as it travels down the pipeline.
	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] avx;
		logic signed [31:0] avy;
		logic signed [31:0] bvx;
		logic signed [31:0] bvy;
		logic signed [31:0] dvx;
		logic signed [31:0] dvy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic [31:0]        ra;
		logic [31:0]        ma;
		logic [31:0]        mb;
		logic [30:0]        hw;
		logic [30:0]        hh;
		logic [32:0]        rsum;
		logic [32:0]        msum;
		logic [15:0]        rest;
		logic               box_in;
		logic [31:0]        dlen;
		logic               hit;
		logic               deg;
		logic               go;
		logic [32:0]        overlap;
	} ccr_ctx_t;

endpackage

FILE: rtl/ccr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ccr_sqrt import ccr_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	logic [63:0] rem_q  [SQRT_STAGES];
	logic [31:0] root_q [SQRT_STAGES];

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
		localparam int B = SQRT_STAGES - 1 - i;
		logic [63:0] rem_in;
		logic [31:0] root_in;
		logic [63:0] trial;

		if (i == 0) begin : g_first
			assign rem_in  = radicand;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_q[i-1];
			assign root_in = root_q[i-1];
		end

		// (R + 2^B)^2 - R^2 = R * 2^(B+1) + 2^(2B)
		assign trial = ({32'd0, root_in} << (B + 1)) | (64'd1 << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_q[i]  <= rem_in - trial;
					root_q[i] <= root_in | (32'd1 << B);
				end else begin
					rem_q[i]  <= rem_in;
					root_q[i] <= root_in;
				end
			end
		end
	end

	assign root = root_q[SQRT_STAGES-1];

endmodule

FILE: rtl/ccr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ccr_div import ccr_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic [30:0] quo
);

	logic [63:0] rem_q [DIV_STAGES];
	logic [30:0] quo_q [DIV_STAGES];
	logic [32:0] den_q [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		localparam int B = DIV_STAGES - 1 - i;
		logic [63:0] rem_in;
		logic [30:0] quo_in;
		logic [32:0] den_in;
		logic [63:0] dsh;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign quo_in = quo_q[i-1];
			assign den_in = den_q[i-1];
		end

		assign dsh = {31'd0, den_in} << B;

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[i] <= den_in;
				if (rem_in >= dsh) begin
					rem_q[i] <= rem_in - dsh;
					quo_q[i] <= quo_in | (31'd1 << B);
				end else begin
					rem_q[i] <= rem_in;
					quo_q[i] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_q[DIV_STAGES-1];

endmodule

FILE: rtl/circle_collision_response.sv
// Top level of the circle collision response pipeline.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tdata body pair, s_tuser kind
//  m_*       out        m_tvalid / m_tready  m_tdata new state, m_tuser flags
//  restit.   in         restitution_wr_en    restitution_wr_data (Q1.15)
//
// One request enters per clock unless the output stalls; each request passes
// four setup stages, 32 square root stages, one contact stage, 31 divider
// stages and six stages of multiply and saturate. The depth is set by the
// bit-serial square root and divider pipelines.
// Reset clears the valid bits and sets restitution to 0.8; the payload
// registers are not reset.
// When the output register holds a result that is not taken, the whole
// pipeline holds and s_tready is low; nothing is dropped or repeated.
module circle_collision_response import ccr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// a_pos, a_vel, a_radius, a_mass, b_pos, b_vel, b_size, b_mass
	input  logic [415:0] s_tdata,
	// operation
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_a_pos, new_a_vel, new_b_pos, new_b_vel
	output logic [255:0] m_tdata,
	// hit, degenerate
	output logic [1:0]   m_tuser,
	input  logic         restitution_wr_en,
	input  logic [15:0]  restitution_wr_data
);

	// Read one lane from the low COORD_WIDTH bits of a 32-bit half.
	function automatic logic signed [31:0] lane(input logic [31:0] h);
		logic signed [COORD_WIDTH-1:0] t;
		t = h[COORD_WIDTH-1:0];
		return 32'(t);
	endfunction

	// Difference saturated to +-(2^31-1).
	function automatic logic signed [31:0] sat_d(input logic signed [32:0] v);
		priority if (v > 33'sd2147483647) return 32'sd2147483647;
		else if (v < -33'sd2147483647) return -32'sd2147483647;
		else return v[31:0];
	endfunction

	// Final lane saturated to the coordinate range and sign extended.
	function automatic logic [31:0] sat_c(input logic signed [37:0] v);
		logic signed [37:0] hi;
		logic signed [37:0] lo;
		hi = (38'sd1 <<< (COORD_WIDTH - 1)) - 38'sd1;
		lo = -hi - 38'sd1;
		priority if (v > hi) return hi[31:0];
		else if (v < lo) return lo[31:0];
		else return v[31:0];
	endfunction

	// Magnitude of a value known to lie within +-(2^31-1).
	function automatic logic [30:0] mag31(input logic signed [31:0] v);
		return v[31] ? 31'(-v) : v[30:0];
	endfunction

	function automatic logic signed [31:0] excess(input logic signed [31:0] d,
		input logic [30:0] half);
		logic [30:0] ad;
		logic [30:0] e;
		ad = mag31(d);
		e  = ad - half;
		if (ad <= half) return '0;
		return d[31] ? -$signed({1'b0, e}) : $signed({1'b0, e});
	endfunction

	// Signed product shifted right, truncated toward zero.
	function automatic logic signed [35:0] mul_shift(input logic signed [35:0] a,
		input logic signed [31:0] b, input int sh);
		logic [35:0] am;
		logic [31:0] bm;
		logic [67:0] p;
		logic [35:0] q;
		am = a[35] ? 36'(-a) : 36'(a);
		bm = b[31] ? 32'(-b) : 32'(b);
		p  = am * bm;
		q  = 36'(p >> sh);
		return (a[35] ^ b[31]) ? $signed(-q) : $signed(q);
	endfunction

	logic        en;
	logic [15:0] rest_q;

	// A stage moves on whenever the output register is free or being emptied.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= REST_RESET;
		end else if (restitution_wr_en) begin
			rest_q <= restitution_wr_data;
		end
	end

	// Stage 1: unpack lanes and take the saturated differences.
	ccr_ctx_t ctx_s1, c1;
	logic     v_s1;

	always_comb begin
		c1     = '0;
		c1.op  = s_tuser;
		c1.ax  = lane(s_tdata[63:32]);
		c1.ay  = lane(s_tdata[31:0]);
		c1.avx = lane(s_tdata[127:96]);
		c1.avy = lane(s_tdata[95:64]);
		c1.ra  = s_tdata[159:128];
		c1.ma  = s_tdata[191:160];
		c1.bx  = lane(s_tdata[255:224]);
		c1.by  = lane(s_tdata[223:192]);
		c1.bvx = lane(s_tdata[319:288]);
		c1.bvy = lane(s_tdata[287:256]);
		c1.hw  = s_tdata[383:353];
		c1.hh  = s_tdata[351:321];
		c1.mb  = s_tdata[415:384];
		c1.rsum = {1'b0, s_tdata[159:128]} + {1'b0, s_tdata[383:352]};
		c1.msum = {1'b0, s_tdata[191:160]} + {1'b0, s_tdata[415:384]};
		c1.rest = rest_q;
		c1.ex   = sat_d(33'(c1.ax) - 33'(c1.bx));
		c1.ey   = sat_d(33'(c1.ay) - 33'(c1.by));
		c1.dvx  = sat_d(33'(c1.avx) - 33'(c1.bvx));
		c1.dvy  = sat_d(33'(c1.avy) - 33'(c1.bvy));
	end

	// Stage 2: box bounds test and the excess over the box half extents.
	ccr_ctx_t ctx_s2, c2;
	logic     v_s2;

	always_comb begin
		c2        = ctx_s1;
		c2.box_in = ({2'b0, mag31(ctx_s1.ex)} < {1'b0, ctx_s1.ra} + {2'b0, ctx_s1.hw}) &&
			({2'b0, mag31(ctx_s1.ey)} < {1'b0, ctx_s1.ra} + {2'b0, ctx_s1.hh});
		if (ctx_s1.op == OP_BOX) begin
			c2.ex = excess(ctx_s1.ex, ctx_s1.hw);
			c2.ey = excess(ctx_s1.ey, ctx_s1.hh);
		end
	end

	// Stage 3: squares; stage 4: their sum feeds the square root.
	ccr_ctx_t    ctx_s3, ctx_s4;
	logic        v_s3, v_s4;
	logic [61:0] sx_s3, sy_s3;
	logic [62:0] rad_s4;

	// Square root section with its context delay line.
	ccr_ctx_t              sq_ctx_q [SQRT_STAGES];
	logic [SQRT_STAGES-1:0] sq_v_q;
	logic [31:0]           root;

	ccr_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({1'b0, rad_s4}),
		.root     (root)
	);

	// Stage 6: contact decision and divider operands.
	ccr_ctx_t    ctx_s6, c6, c5;
	logic        v_s6;
	logic [63:0] nxn_s6, nyn_s6, san_s6, wan_s6, wbn_s6;

	always_comb begin
		c5         = sq_ctx_q[SQRT_STAGES-1];
		c6         = c5;
		c6.dlen    = root;
		c6.hit     = 1'b0;
		c6.deg     = 1'b0;
		c6.go      = 1'b0;
		c6.overlap = c5.rsum - {1'b0, root};
		if (c5.op == OP_CIRCLE) begin
			c6.hit = {1'b0, root} <= c5.rsum;
			c6.deg = c6.hit && (root == '0);
			c6.go  = c6.hit && (root != '0);
		end else if (c5.op == OP_BOX) begin
			c6.hit     = c5.box_in;
			c6.overlap = {1'b0, c5.ra} - {1'b0, root};
			c6.deg     = c5.box_in && (root < c5.ra) && (root == '0);
			c6.go      = c5.box_in && (root < c5.ra) && (root != '0);
		end
	end

	// Divider section: normal components, overlap share and mass fractions.
	ccr_ctx_t              dv_ctx_q [DIV_STAGES];
	logic [DIV_STAGES-1:0] dv_v_q;
	logic [30:0]           q_nx, q_ny, q_sa, q_wa, q_wb;

	ccr_div u_div_nx (.clk(clk), .en(en), .num(nxn_s6), .den({1'b0, ctx_s6.dlen}),
		.quo(q_nx));
	ccr_div u_div_ny (.clk(clk), .en(en), .num(nyn_s6), .den({1'b0, ctx_s6.dlen}),
		.quo(q_ny));
	ccr_div u_div_sa (.clk(clk), .en(en), .num(san_s6), .den(ctx_s6.rsum), .quo(q_sa));
	ccr_div u_div_wa (.clk(clk), .en(en), .num(wan_s6), .den(ctx_s6.msum), .quo(q_wa));
	ccr_div u_div_wb (.clk(clk), .en(en), .num(wbn_s6), .den(ctx_s6.msum), .quo(q_wb));

	// Stage 7: signed normal, position shares and the approach terms.
	ccr_ctx_t           ctx_s7, c7;
	logic               v_s7;
	logic signed [31:0] nx_s7, ny_s7, nx7, ny7;
	logic [16:0]        wa_s7, wb_s7, wa7, wb7, sa7, sb7;
	logic signed [35:0] fa_s7, fb_s7, tvx_s7, tvy_s7;

	always_comb begin
		c7  = dv_ctx_q[DIV_STAGES-1];
		// Zero total mass gives zero fractions.
		wa7 = (c7.msum == '0) ? '0 : q_wa[16:0];
		wb7 = (c7.msum == '0) ? '0 : q_wb[16:0];
		sa7 = (c7.op == OP_CIRCLE) ? q_sa[16:0] : wa7;
		sb7 = (c7.op == OP_CIRCLE) ? q_sa[16:0] : wb7;
		nx7 = c7.ex[31] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
		ny7 = c7.ey[31] ? -$signed({1'b0, q_ny}) : $signed({1'b0, q_ny});
	end

	// Stage 8: position corrections and the normal velocity.
	ccr_ctx_t           ctx_s8;
	logic               v_s8;
	logic signed [31:0] nx_s8, ny_s8;
	logic [16:0]        wa_s8, wb_s8;
	logic signed [35:0] cax_s8, cay_s8, cbx_s8, cby_s8, vn_s8;

	// Stage 9: impulse magnitude and corrected positions.
	ccr_ctx_t           ctx_s9;
	logic               v_s9, vneg_s9;
	logic signed [31:0] nx_s9, ny_s9;
	logic [16:0]        wa_s9, wb_s9;
	logic signed [35:0] k_s9;
	logic [31:0]        pax_s9, pay_s9, pbx_s9, pby_s9;

	// Stage 10: impulse scaled by the mass fractions.
	ccr_ctx_t           ctx_s10;
	logic               v_s10, vneg_s10;
	logic signed [31:0] nx_s10, ny_s10;
	logic signed [35:0] ga_s10, gb_s10;
	logic [63:0]        apos_s10, bpos_s10;

	// Stage 11: velocity changes along the normal.
	ccr_ctx_t           ctx_s11;
	logic               v_s11, vneg_s11;
	logic signed [35:0] dax_s11, day_s11, dbx_s11, dby_s11;
	logic [63:0]        apos_s11, bpos_s11;

	// Stage 12: output register.
	logic        v_s12, hit_s12, deg_s12;
	logic [1:0]  op_s12;
	logic [63:0] apos_s12, avel_s12, bpos_s12, bvel_s12;
	logic [31:0] avx12, avy12, bvx12, bvy12;

	always_comb begin
		avx12 = ctx_s11.avx;
		avy12 = ctx_s11.avy;
		bvx12 = ctx_s11.bvx;
		bvy12 = ctx_s11.bvy;
		if (ctx_s11.op >= OP_UNSUP) begin
			// Unsupported body kind stops the circle.
			avx12 = '0;
			avy12 = '0;
		end else if (ctx_s11.go && vneg_s11) begin
			avx12 = sat_c(38'(ctx_s11.avx) - 38'(dax_s11));
			avy12 = sat_c(38'(ctx_s11.avy) - 38'(day_s11));
			bvx12 = sat_c(38'(ctx_s11.bvx) + 38'(dbx_s11));
			bvy12 = sat_c(38'(ctx_s11.bvy) + 38'(dby_s11));
		end
	end

	// Valid bits, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			sq_v_q <= '0;
			v_s6   <= 1'b0;
			dv_v_q <= '0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			v_s10  <= 1'b0;
			v_s11  <= 1'b0;
			v_s12  <= 1'b0;
		end else if (en) begin
			v_s1   <= s_tvalid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			sq_v_q <= {sq_v_q[SQRT_STAGES-2:0], v_s4};
			v_s6   <= sq_v_q[SQRT_STAGES-1];
			dv_v_q <= {dv_v_q[DIV_STAGES-2:0], v_s6};
			v_s7   <= dv_v_q[DIV_STAGES-1];
			v_s8   <= v_s7;
			v_s9   <= v_s8;
			v_s10  <= v_s9;
			v_s11  <= v_s10;
			v_s12  <= v_s11;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= c1;
			ctx_s2 <= c2;

			ctx_s3 <= ctx_s2;
			sx_s3  <= 62'(mag31(ctx_s2.ex) * mag31(ctx_s2.ex));
			sy_s3  <= 62'(mag31(ctx_s2.ey) * mag31(ctx_s2.ey));

			ctx_s4 <= ctx_s3;
			rad_s4 <= {1'b0, sx_s3} + {1'b0, sy_s3};

			sq_ctx_q[0] <= ctx_s4;
			for (int i = 1; i < SQRT_STAGES; i++) begin
				sq_ctx_q[i] <= sq_ctx_q[i-1];
			end

			ctx_s6 <= c6;
			nxn_s6 <= {3'd0, mag31(c5.ex), 30'd0};
			nyn_s6 <= {3'd0, mag31(c5.ey), 30'd0};
			san_s6 <= {15'd0, c6.overlap, 16'd0};
			wan_s6 <= {16'd0, c5.ma, 16'd0};
			wbn_s6 <= {16'd0, c5.mb, 16'd0};

			dv_ctx_q[0] <= ctx_s6;
			for (int i = 1; i < DIV_STAGES; i++) begin
				dv_ctx_q[i] <= dv_ctx_q[i-1];
			end

			ctx_s7 <= c7;
			nx_s7  <= nx7;
			ny_s7  <= ny7;
			wa_s7  <= wa7;
			wb_s7  <= wb7;
			fa_s7  <= mul_shift($signed({3'd0, c7.overlap}), $signed({15'd0, sa7}), 16);
			fb_s7  <= mul_shift($signed({3'd0, c7.overlap}), $signed({15'd0, sb7}), 16);
			tvx_s7 <= mul_shift(36'(c7.dvx), nx7, 30);
			tvy_s7 <= mul_shift(36'(c7.dvy), ny7, 30);

			ctx_s8 <= ctx_s7;
			nx_s8  <= nx_s7;
			ny_s8  <= ny_s7;
			wa_s8  <= wa_s7;
			wb_s8  <= wb_s7;
			cax_s8 <= mul_shift(fa_s7, nx_s7, 30);
			cay_s8 <= mul_shift(fa_s7, ny_s7, 30);
			cbx_s8 <= mul_shift(fb_s7, nx_s7, 30);
			cby_s8 <= mul_shift(fb_s7, ny_s7, 30);
			vn_s8  <= tvx_s7 + tvy_s7;

			ctx_s9  <= ctx_s8;
			nx_s9   <= nx_s8;
			ny_s9   <= ny_s8;
			wa_s9   <= wa_s8;
			wb_s9   <= wb_s8;
			vneg_s9 <= vn_s8[35];
			k_s9    <= mul_shift(vn_s8, $signed({15'd0, Q15_ONE + {1'b0, ctx_s8.rest}}), 15);
			if (ctx_s8.go) begin
				pax_s9 <= sat_c(38'(ctx_s8.ax) + 38'(cax_s8));
				pay_s9 <= sat_c(38'(ctx_s8.ay) + 38'(cay_s8));
				pbx_s9 <= sat_c(38'(ctx_s8.bx) - 38'(cbx_s8));
				pby_s9 <= sat_c(38'(ctx_s8.by) - 38'(cby_s8));
			end else begin
				pax_s9 <= ctx_s8.ax;
				pay_s9 <= ctx_s8.ay;
				pbx_s9 <= ctx_s8.bx;
				pby_s9 <= ctx_s8.by;
			end

			ctx_s10  <= ctx_s9;
			nx_s10   <= nx_s9;
			ny_s10   <= ny_s9;
			vneg_s10 <= vneg_s9;
			ga_s10   <= mul_shift(k_s9, $signed({15'd0, wb_s9}), 16);
			gb_s10   <= mul_shift(k_s9, $signed({15'd0, wa_s9}), 16);
			apos_s10 <= {pax_s9, pay_s9};
			bpos_s10 <= {pbx_s9, pby_s9};

			ctx_s11  <= ctx_s10;
			vneg_s11 <= vneg_s10;
			dax_s11  <= mul_shift(ga_s10, nx_s10, 30);
			day_s11  <= mul_shift(ga_s10, ny_s10, 30);
			dbx_s11  <= mul_shift(gb_s10, nx_s10, 30);
			dby_s11  <= mul_shift(gb_s10, ny_s10, 30);
			apos_s11 <= apos_s10;
			bpos_s11 <= bpos_s10;

			hit_s12  <= ctx_s11.hit;
			deg_s12  <= ctx_s11.deg;
			op_s12   <= ctx_s11.op;
			apos_s12 <= apos_s11;
			bpos_s12 <= bpos_s11;
			avel_s12 <= {avx12, avy12};
			bvel_s12 <= {bvx12, bvy12};
		end
	end

	assign m_tvalid = v_s12;
	assign m_tdata  = {bvel_s12, bpos_s12, avel_s12, apos_s12};
	assign m_tuser  = {deg_s12, hit_s12};

	// A degenerate contact is always a contact.
	a_deg_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hit_s12 || !deg_s12))
		else $error("degenerate result without contact");

	// The contact stage never both skips and applies a correction.
	a_deg_go: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> !(ctx_s6.deg && ctx_s6.go))
		else $error("degenerate and corrected at once");

	// Unsupported kinds report no contact and a stopped circle.
	a_unsup: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && op_s12 >= OP_UNSUP) |-> (!hit_s12 && avel_s12 == '0))
		else $error("unsupported kind not handled");

	// A stalled output freezes the inner pipeline.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(v_s6) && $stable(ctx_s6.dlen)))
		else $error("pipeline moved during a stall");

endmodule
